// ===== rtl/lidar_point_convert_self_filter_macros.svh =====
// Assertion macros shared by the lidar point converter RTL.
// Included by every module that carries concurrent checks; no other dependencies.
`ifndef LIDAR_POINT_CONVERT_SELF_FILTER_MACROS_SVH
`define LIDAR_POINT_CONVERT_SELF_FILTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define LPCSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPCSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define LPCSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LPCSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/lpcsf_pkg.sv =====
// Shared types and constants of the lidar point converter with self-body filter.
// No dependencies; imported by every module of the block.
package lpcsf_pkg;

	localparam int TS_BITS    = 63;
	localparam int REL_BITS   = 32;
	localparam int INTEN_BITS = 8;
	localparam int MODE_BITS  = 2;
	localparam int YAW_BITS   = 22;

	// Output modes; the fourth code behaves as the no-ring mode.
	localparam logic [MODE_BITS-1:0] MODE_FULL    = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_NO_TIME = 2'd1;

	// Yaw directions as cos and sin scaled by 2^20.
	localparam logic signed [YAW_BITS-1:0] C70  = 22'sd358634;
	localparam logic signed [YAW_BITS-1:0] S70  = 22'sd985339;
	localparam logic signed [YAW_BITS-1:0] C72  = 22'sd324028;
	localparam logic signed [YAW_BITS-1:0] S72  = 22'sd997255;
	localparam logic signed [YAW_BITS-1:0] C130 = -22'sd674012;
	localparam logic signed [YAW_BITS-1:0] S130 = 22'sd803256;
	localparam logic signed [YAW_BITS-1:0] C160 = -22'sd985339;
	localparam logic signed [YAW_BITS-1:0] S160 = 22'sd358634;

	// Squared radius limits in mm^2.
	localparam logic [31:0] R2_CORE  = 32'd122500;
	localparam logic [31:0] R2_RING  = 32'd250000;
	localparam logic [31:0] R2_LOW   = 32'd1000000;
	localparam logic [31:0] R2_SIDE  = 32'd336400;
	localparam logic [31:0] R2_REAR  = 32'd2190400;

	// Box and height limits in mm.
	localparam int X_BOX_MIN  = -750;
	localparam int Y_BOX_LIM  = 410;
	localparam int Z_CORE_MIN = -570;
	localparam int Z_BOX_MIN  = -470;
	localparam int Z_TOP      = 200;
	localparam int Z_LOW_MIN  = -200;
	localparam int Z_REAR_MIN = -420;

	// Stage load enables from the pipeline control.
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
	} pipe_ctl_t;

endpackage

// ===== rtl/lpcsf_zone.sv =====
// Self-body zone test, pipelined over stages two and three.
// Depends on lpcsf_pkg and the assertion macro header.
`include "lidar_point_convert_self_filter_macros.svh"
module lpcsf_zone #(
	parameter int COORD_BITS = 19,
	parameter int RING_BITS  = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lpcsf_pkg::pipe_ctl_t         ctl,
	input  logic signed [COORD_BITS-1:0] x_s1,
	input  logic signed [COORD_BITS-1:0] y_s1,
	input  logic signed [COORD_BITS-1:0] z_s1,
	input  logic [RING_BITS-1:0]         ring_s1,
	output logic                         in_zone_s3
);
	import lpcsf_pkg::*;

	localparam int PW  = 2 * COORD_BITS;
	localparam int R2W = PW + 1;
	localparam int XW  = COORD_BITS + YAW_BITS + 1;

	typedef struct packed {
		logic box;
		logic z_core;
		logic z_low;
		logic z_mid;
		logic z_rear;
		logic ring_le5;
		logic ring_le7;
		logic ring_eq10;
		logic ring_le10;
		logic ring_le13;
		logic ring_le15;
	} geo_flags_t;

	logic [COORD_BITS-1:0]   ax_c, ay_c;
	logic signed [COORD_BITS:0] ay_sx;
	geo_flags_t              geo_c, geo_s2, geo_s3;

	logic [PW-1:0]           axx_s2, ayy_s2;
	logic signed [XW-1:0]    cy70_s2, sx70_s2, cy72_s2, sx72_s2;
	logic signed [XW-1:0]    cy130_s2, sx130_s2, cy160_s2, sx160_s2;

	logic [R2W-1:0]          r2_c;
	logic signed [XW-1:0]    d70_c, d72_c, d130_c, d160_c;

	logic r2_core_s3, r2_ring_s3, r2_low_s3, r2_side_s3, r2_rear_s3;
	logic gt70_s3, gt72_s3, gt130_s3, lt130_s3, gt160_s3;

	// The most negative coordinate still fits as an unsigned magnitude.
	assign ax_c  = x_s1[COORD_BITS-1] ? COORD_BITS'(-x_s1) : COORD_BITS'(x_s1);
	assign ay_c  = y_s1[COORD_BITS-1] ? COORD_BITS'(-y_s1) : COORD_BITS'(y_s1);
	assign ay_sx = $signed({1'b0, ay_c});

	always_comb begin
		geo_c.box       = (x_s1 > X_BOX_MIN) && (x_s1 < 0) && (y_s1 > -Y_BOX_LIM) &&
		                  (y_s1 < Y_BOX_LIM) && (z_s1 > Z_BOX_MIN) && (z_s1 < Z_TOP);
		geo_c.z_core    = z_s1 > Z_CORE_MIN;
		geo_c.z_low     = (z_s1 > Z_LOW_MIN) && (z_s1 < Z_TOP);
		geo_c.z_mid     = (z_s1 > Z_BOX_MIN) && (z_s1 < Z_TOP);
		geo_c.z_rear    = z_s1 > Z_REAR_MIN;
		geo_c.ring_le5  = ring_s1 <= 5;
		geo_c.ring_le7  = ring_s1 <= 7;
		geo_c.ring_eq10 = ring_s1 == 10;
		geo_c.ring_le10 = ring_s1 <= 10;
		geo_c.ring_le13 = ring_s1 <= 13;
		geo_c.ring_le15 = ring_s1 <= 15;
	end

	// Stage two: squares and the constant-coefficient products.
	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			axx_s2   <= ax_c * ax_c;
			ayy_s2   <= ay_c * ay_c;
			cy70_s2  <= C70 * ay_sx;
			sx70_s2  <= S70 * x_s1;
			cy72_s2  <= C72 * ay_sx;
			sx72_s2  <= S72 * x_s1;
			cy130_s2 <= C130 * ay_sx;
			sx130_s2 <= S130 * x_s1;
			cy160_s2 <= C160 * ay_sx;
			sx160_s2 <= S160 * x_s1;
			geo_s2   <= geo_c;
		end
	end

	assign r2_c   = R2W'(axx_s2) + R2W'(ayy_s2);
	assign d70_c  = cy70_s2 - sx70_s2;
	assign d72_c  = cy72_s2 - sx72_s2;
	assign d130_c = cy130_s2 - sx130_s2;
	assign d160_c = cy160_s2 - sx160_s2;

	// Stage three: radius compares and the sign of each cross product.
	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			r2_core_s3 <= r2_c < R2_CORE;
			r2_ring_s3 <= r2_c < R2_RING;
			r2_low_s3  <= r2_c < R2_LOW;
			r2_side_s3 <= r2_c < R2_SIDE;
			r2_rear_s3 <= r2_c < R2_REAR;
			gt70_s3    <= d70_c > 0;
			gt72_s3    <= d72_c > 0;
			gt130_s3   <= d130_c > 0;
			lt130_s3   <= d130_c < 0;
			gt160_s3   <= d160_c > 0;
			geo_s3     <= geo_s2;
		end
	end

	assign in_zone_s3 =
		(r2_core_s3 && geo_s3.z_core) ||
		geo_s3.box ||
		(gt70_s3 && lt130_s3 && (geo_s3.ring_le7 || (geo_s3.ring_eq10 && r2_ring_s3))) ||
		(geo_s3.ring_le10 && r2_low_s3 && geo_s3.z_low) ||
		(gt130_s3 && geo_s3.ring_le5) ||
		(geo_s3.ring_le15 && r2_side_s3 && geo_s3.z_mid && gt72_s3) ||
		(geo_s3.ring_le13 && r2_rear_s3 && geo_s3.z_rear && gt160_s3);

	// A cross product cannot be both above and below its threshold.
	`LPCSF_ASSERT_IMP(a_yaw_exclusive, clk, arst_n, gt130_s3, !lt130_s3)

endmodule

// ===== rtl/lpcsf_reltime.sv =====
// Frame start latch and saturated relative time, aligned to stage three.
// Depends on lpcsf_pkg and the assertion macro header.
`include "lidar_point_convert_self_filter_macros.svh"
module lpcsf_reltime (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lpcsf_pkg::pipe_ctl_t            ctl,
	input  logic                            in_acc,
	input  logic                            first,
	input  logic [lpcsf_pkg::TS_BITS-1:0]   ts,
	output logic signed [lpcsf_pkg::REL_BITS-1:0] rel_s3
);
	import lpcsf_pkg::*;

	localparam int DW = TS_BITS + 1;

	logic [TS_BITS-1:0]     fst_q, ts_s1, fst_s1;
	logic signed [DW-1:0]   diff_s2;
	logic                   in_range_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q <= '0;
		end else if (in_acc && first) begin
			fst_q <= ts;
		end
	end

	// A frame's first request is timed against its own timestamp.
	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			ts_s1  <= ts;
			fst_s1 <= (in_acc && first) ? ts : fst_q;
		end
		if (ctl.ld_s2) begin
			diff_s2 <= $signed({1'b0, ts_s1}) - $signed({1'b0, fst_s1});
		end
	end

	assign in_range_c = (&diff_s2[DW-1:REL_BITS-1]) || !(|diff_s2[DW-1:REL_BITS-1]);

	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			if (in_range_c) begin
				rel_s3 <= diff_s2[REL_BITS-1:0];
			end else if (diff_s2[DW-1]) begin
				rel_s3 <= {1'b1, {(REL_BITS-1){1'b0}}};
			end else begin
				rel_s3 <= {1'b0, {(REL_BITS-1){1'b1}}};
			end
		end
	end

	`LPCSF_ASSERT_NEXT(a_frame_latch, clk, arst_n, in_acc && first, fst_q == $past(ts))

endmodule

// ===== rtl/lidar_point_convert_self_filter.sv =====
// Lidar point converter with vehicle self-body filter, top level.
// Depends on lpcsf_pkg, lpcsf_zone, lpcsf_reltime and the assertion macro header.
//
// Points enter on the s_axis channel, one request per cycle at most; tdata
// packs x, y, z, intensity, ring and the nanosecond timestamp, tuser carries
// the invalid flag and the frame-start flag. Kept points leave on m_axis.
// The output mode register is written through cfg_wr_en / cfg_wr_data.
// The pipeline has four register stages (input, products, compares, output
// register); an accepted point passes through them in that order before it is
// offered on m_axis. Throughput is one point per cycle while m_axis does not stall.
// Dropped points leave a bubble and produce no output request.
// When the receiver stalls, each stage holds until the one after it is free,
// so empty stages still accept; s_axis_tready falls only when all are full.
// Reset clears the valid bits, the frame start time and the mode (full mode).
`include "lidar_point_convert_self_filter_macros.svh"
module lidar_point_convert_self_filter #(
	parameter int COORD_BITS = 19,
	parameter int RING_BITS  = 8,
	localparam int IW = ((3 * COORD_BITS + 8 + RING_BITS + 63 + 7) / 8) * 8,
	localparam int OW = ((3 * COORD_BITS + 8 + RING_BITS + 32 + 7) / 8) * 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [1:0]    cfg_wr_data,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// x_mm, y_mm, z_mm, intensity, ring, timestamp_ns (lowest bit first)
	input  logic [IW-1:0] s_axis_tdata,
	// coord_invalid, first_of_frame (lowest bit first)
	input  logic [1:0]    s_axis_tuser,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// x_out, y_out, z_out, intensity_out, ring_out, rel_time_ns (lowest bit first)
	output logic [OW-1:0] m_axis_tdata
);
	import lpcsf_pkg::*;

	localparam int X_LO  = 0;
	localparam int Y_LO  = COORD_BITS;
	localparam int Z_LO  = 2 * COORD_BITS;
	localparam int I_LO  = 3 * COORD_BITS;
	localparam int R_LO  = I_LO + INTEN_BITS;
	localparam int T_LO  = R_LO + RING_BITS;
	localparam int OUT_W = T_LO + REL_BITS;

	logic [MODE_BITS-1:0] mode_q;
	pipe_ctl_t            ctl;
	logic                 rdy1_c, rdy2_c, rdy3_c, rdy4_c, in_acc_c;
	logic                 v1_s1, v2_s2, v3_s3, v4_s4;
	logic                 in_zone_s3, keep_c, drop_ring_c;
	logic signed [REL_BITS-1:0] rel_s3, rel_s4;

	logic signed [COORD_BITS-1:0] x_s1, y_s1, z_s1, x_s2, y_s2, z_s2;
	logic signed [COORD_BITS-1:0] x_s3, y_s3, z_s3, x_s4, y_s4, z_s4;
	logic [INTEN_BITS-1:0] inten_s1, inten_s2, inten_s3, inten_s4;
	logic [RING_BITS-1:0]  ring_s1, ring_s2, ring_s3, ring_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FULL;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	assign rdy4_c = !v4_s4 || m_axis_tready;
	assign rdy3_c = !v3_s3 || rdy4_c;
	assign rdy2_c = !v2_s2 || rdy3_c;
	assign rdy1_c = !v1_s1 || rdy2_c;

	assign s_axis_tready = rdy1_c;
	assign in_acc_c      = s_axis_tvalid && rdy1_c;
	assign ctl.ld_s1     = rdy1_c;
	assign ctl.ld_s2     = rdy2_c;
	assign ctl.ld_s3     = rdy3_c;

	assign keep_c      = (mode_q != MODE_FULL) || !in_zone_s3;
	assign drop_ring_c = (mode_q != MODE_FULL) && (mode_q != MODE_NO_TIME);

	// Invalid points never enter the pipeline as valid requests.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (rdy1_c) begin
				v1_s1 <= s_axis_tvalid && !s_axis_tuser[0];
			end
			if (rdy2_c) begin
				v2_s2 <= v1_s1;
			end
			if (rdy3_c) begin
				v3_s3 <= v2_s2;
			end
			if (rdy4_c) begin
				v4_s4 <= v3_s3 && keep_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1_c) begin
			x_s1     <= s_axis_tdata[X_LO +: COORD_BITS];
			y_s1     <= s_axis_tdata[Y_LO +: COORD_BITS];
			z_s1     <= s_axis_tdata[Z_LO +: COORD_BITS];
			inten_s1 <= s_axis_tdata[I_LO +: INTEN_BITS];
			ring_s1  <= s_axis_tdata[R_LO +: RING_BITS];
		end
		if (rdy2_c) begin
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			z_s2     <= z_s1;
			inten_s2 <= inten_s1;
			ring_s2  <= ring_s1;
		end
		if (rdy3_c) begin
			x_s3     <= x_s2;
			y_s3     <= y_s2;
			z_s3     <= z_s2;
			inten_s3 <= inten_s2;
			ring_s3  <= ring_s2;
		end
		if (rdy4_c) begin
			x_s4     <= x_s3;
			y_s4     <= y_s3;
			z_s4     <= z_s3;
			inten_s4 <= inten_s3;
			ring_s4  <= drop_ring_c ? '0 : ring_s3;
			rel_s4   <= (mode_q == MODE_FULL) ? rel_s3 : '0;
		end
	end

	lpcsf_zone #(
		.COORD_BITS (COORD_BITS),
		.RING_BITS  (RING_BITS)
	) u_zone (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.x_s1       (x_s1),
		.y_s1       (y_s1),
		.z_s1       (z_s1),
		.ring_s1    (ring_s1),
		.in_zone_s3 (in_zone_s3)
	);

	lpcsf_reltime u_reltime (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.in_acc (in_acc_c),
		.first  (s_axis_tuser[1]),
		.ts     (s_axis_tdata[T_LO +: TS_BITS]),
		.rel_s3 (rel_s3)
	);

	assign m_axis_tvalid = v4_s4;
	assign m_axis_tdata  = OW'({rel_s4, ring_s4, inten_s4, z_s4, y_s4, x_s4});

	// An empty output stage means every stage can move, so input is open.
	`LPCSF_ASSERT_IMP(a_open_when_empty, clk, arst_n, !v4_s4, s_axis_tready)
	// An accepted invalid point leaves no valid request behind it.
	`LPCSF_ASSERT_NEXT(a_drop_invalid, clk, arst_n, in_acc_c && s_axis_tuser[0], !v1_s1)
	// A blocked stage two keeps its request and payload.
	`LPCSF_ASSERT_NEXT(a_hold_s2, clk, arst_n, v2_s2 && !rdy2_c, v2_s2 && $stable(x_s2))
	// Output data width covers all packed result fields.
	`LPCSF_ASSERT_IMP(a_width_fit, clk, arst_n, m_axis_tvalid, OW >= OUT_W)

endmodule

// ===== tb/point_stream_checker.sv =====
`timescale 1ns / 100ps
// Stream checker for the lidar point converter: predicts kept points and compares them.
// Depends on lpcsf_pkg for the mode codes and field widths; instantiated by tb_top.
module point_stream_checker
	import lpcsf_pkg::TS_BITS;
	import lpcsf_pkg::REL_BITS;
	import lpcsf_pkg::INTEN_BITS;
	import lpcsf_pkg::MODE_BITS;
	import lpcsf_pkg::MODE_FULL;
	import lpcsf_pkg::MODE_NO_TIME;
#(
	parameter int CW = 19,
	parameter int RW = 8,
	parameter int IW = 136,
	parameter int OW = 112
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [MODE_BITS-1:0] cfg_wr_data,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	// x_mm, y_mm, z_mm, intensity, ring, timestamp_ns (lowest bit first)
	input  logic [IW-1:0]        s_tdata,
	// coord_invalid, first_of_frame (lowest bit first)
	input  logic [1:0]           s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	// x_out, y_out, z_out, intensity_out, ring_out, rel_time_ns (lowest bit first)
	input  logic [OW-1:0]        m_tdata,
	output int                   mismatch_count,
	output int                   pending_points
);

	localparam int X_LO     = 0;
	localparam int Y_LO     = CW;
	localparam int Z_LO     = 2 * CW;
	localparam int INTEN_LO = 3 * CW;
	localparam int RING_LO  = INTEN_LO + INTEN_BITS;
	localparam int TS_LO    = RING_LO + RW;
	localparam int REL_LO   = RING_LO + RW;
	localparam int MAX_REPORTS = 10;

	localparam longint REL_MAX = 64'sd2147483647;
	localparam longint REL_MIN = -64'sd2147483648;

	// Yaw thresholds as unit directions scaled by 2^20.
	localparam longint COS70_Q  = 358634;
	localparam longint SIN70_Q  = 985339;
	localparam longint COS72_Q  = 324028;
	localparam longint SIN72_Q  = 997255;
	localparam longint COS130_Q = -674012;
	localparam longint SIN130_Q = 803256;
	localparam longint COS160_Q = -985339;
	localparam longint SIN160_Q = 358634;

	typedef struct packed {
		logic [CW-1:0]         x;
		logic [CW-1:0]         y;
		logic [CW-1:0]         z;
		logic [INTEN_BITS-1:0] inten;
		logic [RW-1:0]         ring;
		logic [REL_BITS-1:0]   rel;
	} kept_point_t;

	logic [MODE_BITS-1:0] out_mode;
	logic [TS_BITS-1:0]   frame_start_ns;
	kept_point_t          expected_points_q[$];

	initial begin
		mismatch_count = 0;
		pending_points = 0;
	end

	function automatic bit in_vehicle_body(input longint x, input longint y, input longint z,
			input int ring);
		longint ax;
		longint ay;
		longint r2;
		bit     gt70;
		bit     gt72;
		bit     gt130;
		bit     lt130;
		bit     gt160;
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		r2 = ax * ax + ay * ay;
		// The sign of the cross product with the threshold direction tells the side.
		gt70  = (COS70_Q * ay - SIN70_Q * x) > 0;
		gt72  = (COS72_Q * ay - SIN72_Q * x) > 0;
		gt130 = (COS130_Q * ay - SIN130_Q * x) > 0;
		lt130 = (COS130_Q * ay - SIN130_Q * x) < 0;
		gt160 = (COS160_Q * ay - SIN160_Q * x) > 0;
		if (r2 < 122500 && z > -570)
			return 1'b1;
		if (x > -750 && x < 0 && y > -410 && y < 410 && z > -470 && z < 200)
			return 1'b1;
		if (gt70 && lt130 && (ring <= 7 || (ring == 10 && r2 < 250000)))
			return 1'b1;
		if (ring <= 10 && r2 < 1000000 && z > -200 && z < 200)
			return 1'b1;
		if (gt130 && ring <= 5)
			return 1'b1;
		if (ring <= 15 && r2 < 336400 && z > -470 && z < 200 && gt72)
			return 1'b1;
		if (ring <= 13 && r2 < 2190400 && z > -420 && gt160)
			return 1'b1;
		return 1'b0;
	endfunction

	// Returns 1 and the converted point when a valid point survives the filter.
	function automatic bit convert_point(input logic [IW-1:0] d, output kept_point_t p);
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic [RW-1:0]        ring;
		logic [TS_BITS-1:0]   ts;
		longint               dt;
		x    = d[X_LO +: CW];
		y    = d[Y_LO +: CW];
		z    = d[Z_LO +: CW];
		ring = d[RING_LO +: RW];
		ts   = d[TS_LO +: TS_BITS];
		p    = '0;
		if (out_mode == MODE_FULL && in_vehicle_body(x, y, z, int'(ring)))
			return 1'b0;
		p.x     = x;
		p.y     = y;
		p.z     = z;
		p.inten = d[INTEN_LO +: INTEN_BITS];
		p.ring  = (out_mode == MODE_FULL || out_mode == MODE_NO_TIME) ? ring : '0;
		if (out_mode == MODE_FULL) begin
			dt = longint'({1'b0, ts}) - longint'({1'b0, frame_start_ns});
			if (dt > REL_MAX)
				p.rel = REL_MAX[REL_BITS-1:0];
			else if (dt < REL_MIN)
				p.rel = REL_MIN[REL_BITS-1:0];
			else
				p.rel = dt[REL_BITS-1:0];
		end
		return 1'b1;
	endfunction

	function automatic void check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		kept_point_t want;
		kept_point_t fresh;
		if (!arst_n) begin
			out_mode       = MODE_FULL;
			frame_start_ns = '0;
			expected_points_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_points_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: unexpected output request, data %h", $realtime, m_tdata);
				end else begin
					want = expected_points_q.pop_front();
					check_field("x_out", $signed(want.x), $signed(m_tdata[X_LO +: CW]));
					check_field("y_out", $signed(want.y), $signed(m_tdata[Y_LO +: CW]));
					check_field("z_out", $signed(want.z), $signed(m_tdata[Z_LO +: CW]));
					check_field("intensity_out", want.inten, m_tdata[INTEN_LO +: INTEN_BITS]);
					check_field("ring_out", want.ring, m_tdata[RING_LO +: RW]);
					check_field("rel_time_ns", $signed(want.rel),
						$signed(m_tdata[REL_LO +: REL_BITS]));
				end
			end
			if (cfg_wr_en)
				out_mode = cfg_wr_data;
			if (s_tvalid && s_tready) begin
				// The frame start is latched even when the point itself is dropped.
				if (s_tuser[1])
					frame_start_ns = s_tdata[TS_LO +: TS_BITS];
				if (!s_tuser[0] && convert_point(s_tdata, fresh))
					expected_points_q = {expected_points_q, fresh};
			end
		end
		pending_points = expected_points_q.size();
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the lidar point converter testbench: clock, reset, point stimulus and verdict.
// Depends on lpcsf_pkg, the converter RTL and point_stream_checker.
module tb_top;
	import lpcsf_pkg::TS_BITS;
	import lpcsf_pkg::INTEN_BITS;
	import lpcsf_pkg::MODE_BITS;
	import lpcsf_pkg::MODE_FULL;
	import lpcsf_pkg::MODE_NO_TIME;

	localparam int CW = 19;
	localparam int RW = 8;
	localparam int IW = ((3 * CW + 8 + RW + 63 + 7) / 8) * 8;
	localparam int OW = ((3 * CW + 8 + RW + 32 + 7) / 8) * 8;

	localparam int X_LO     = 0;
	localparam int Y_LO     = CW;
	localparam int Z_LO     = 2 * CW;
	localparam int INTEN_LO = 3 * CW;
	localparam int RING_LO  = INTEN_LO + INTEN_BITS;
	localparam int TS_LO    = RING_LO + RW;

	localparam logic [MODE_BITS-1:0] MODE_NO_RING     = 2'd2;
	localparam logic [MODE_BITS-1:0] MODE_NO_RING_ALT = 2'd3;

	localparam int DRAIN_CYCLES = 12;
	localparam int LIMIT_NS     = 1000000;

	localparam logic [TS_BITS-1:0] TS_MAX    = '1;
	localparam logic [TS_BITS-1:0] FRAME0_NS = 63'h100_0000_0000;
	localparam logic [TS_BITS-1:0] SPAN_NS   = 63'h7fff_ffff;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [MODE_BITS-1:0] cfg_wr_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [IW-1:0]        s_axis_tdata;
	logic [1:0]           s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [OW-1:0]        m_axis_tdata;

	int mismatch_count;
	int pending_points;

	int                 burst_left;
	int                 frame_points_left;
	logic [TS_BITS-1:0] frame_base_ns;
	logic [TS_BITS-1:0] frame_offset_ns;

	lidar_point_convert_self_filter #(
		.COORD_BITS(CW),
		.RING_BITS (RW)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	point_stream_checker #(
		.CW(CW),
		.RW(RW),
		.IW(IW),
		.OW(OW)
	) checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_tvalid      (s_axis_tvalid),
		.s_tready      (s_axis_tready),
		.s_tdata       (s_axis_tdata),
		.s_tuser       (s_axis_tuser),
		.m_tvalid      (m_axis_tvalid),
		.m_tready      (m_axis_tready),
		.m_tdata       (m_axis_tdata),
		.mismatch_count(mismatch_count),
		.pending_points(pending_points)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("CHECK FAILED");
		$finish;
	end

	// The receiver keeps its own rhythm: runs of ready, short stalls, now and then a long run.
	initial begin
		int run_len;
		int stall_len;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			run_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
			stall_len = $urandom_range(1, 7);
			@(negedge clk) m_axis_tready <= 1'b1;
			repeat (run_len - 1) @(negedge clk);
			@(negedge clk) m_axis_tready <= 1'b0;
			repeat (stall_len - 1) @(negedge clk);
		end
	end

	function automatic logic [TS_BITS-1:0] random_ts();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[TS_BITS-1:0];
	endfunction

	task automatic send_point(input int x, input int y, input int z, input int inten,
			input int ring, input logic [TS_BITS-1:0] ts, input bit invalid, input bit first);
		logic [IW-1:0] d;
		int            gap;
		logic [31:0]   xv;
		logic [31:0]   yv;
		logic [31:0]   zv;
		logic [31:0]   iv;
		logic [31:0]   rv;
		xv = x;
		yv = y;
		zv = z;
		iv = inten;
		rv = ring;
		d = '0;
		d[X_LO +: CW]             = xv[CW-1:0];
		d[Y_LO +: CW]             = yv[CW-1:0];
		d[Z_LO +: CW]             = zv[CW-1:0];
		d[INTEN_LO +: INTEN_BITS] = iv[INTEN_BITS-1:0];
		d[RING_LO +: RW]          = rv[RW-1:0];
		d[TS_LO +: TS_BITS]       = ts;
		@(negedge clk);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
				$urandom_range(1, 24);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		s_axis_tuser  <= {first, invalid};
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// Holds the sender off until every expected point is out and the pipeline is empty.
	task automatic wait_for_drain();
		@(negedge clk) s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_points != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_mode(input logic [MODE_BITS-1:0] mode);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= mode;
		@(negedge clk) cfg_wr_en <= 1'b0;
	endtask

	// Mostly whole frames with rising timestamps near the vehicle, plus some noise.
	task automatic send_random_points(input int count);
		int                 x;
		int                 y;
		int                 z;
		int                 ring;
		bit                 first;
		bit                 invalid;
		logic [TS_BITS-1:0] ts;
		for (int i = 0; i < count; i++) begin
			first = 1'b0;
			if (frame_points_left == 0) begin
				frame_points_left = $urandom_range(4, 60);
				frame_base_ns     = ($urandom_range(0, 3) == 0) ? random_ts() :
					(TS_BITS'($urandom) << 12);
				frame_offset_ns   = '0;
				first             = 1'b1;
			end
			frame_points_left--;
			if ($urandom_range(0, 99) < 85) begin
				frame_offset_ns += $urandom_range(0, 300000);
				// Now and then a jump across the 32-bit relative time limit.
				if ($urandom_range(0, 39) == 0)
					frame_offset_ns += 63'd2147000000 + $urandom_range(0, 1000000);
				ts = frame_base_ns + frame_offset_ns;
				if ($urandom_range(0, 29) == 0)
					ts = frame_base_ns - $urandom_range(0, 5000);
			end else begin
				ts    = random_ts();
				first = first | ($urandom_range(0, 9) == 0);
			end
			if ($urandom_range(0, 9) < 7) begin
				x = int'($urandom_range(0, 6000)) - 3000;
				y = int'($urandom_range(0, 6000)) - 3000;
				z = int'($urandom_range(0, 1400)) - 900;
			end else begin
				x = $urandom;
				y = $urandom;
				z = $urandom;
			end
			ring    = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 16) : $urandom_range(0, 255);
			invalid = ($urandom_range(0, 19) == 0);
			send_point(x, y, z, $urandom_range(0, 255), ring, ts, invalid, first);
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_wr_en         = 1'b0;
		cfg_wr_data       = '0;
		s_axis_tvalid     = 1'b0;
		s_axis_tdata      = '0;
		s_axis_tuser      = '0;
		burst_left        = 0;
		frame_points_left = 0;
		frame_base_ns     = '0;
		frame_offset_ns   = '0;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		write_mode(MODE_FULL);
		// Before any frame start, times count from zero.
		send_point(100000, 0, 0, 0, 100, 63'd5000, 1'b0, 1'b0);
		send_point(100000, 5, 7, 255, 255, TS_MAX, 1'b0, 1'b0);
		// An invalid point still opens the frame.
		send_point(0, 0, 0, 1, 1, FRAME0_NS, 1'b1, 1'b1);
		send_point(50000, -20000, 300, 10, 200, FRAME0_NS + 63'd123, 1'b0, 1'b0);
		send_point(50000, 20000, -300, 11, 201, FRAME0_NS - 63'd5, 1'b0, 1'b0);
		send_point(60000, 1, 2, 12, 202, FRAME0_NS + SPAN_NS, 1'b0, 1'b0);
		send_point(60000, 1, 2, 13, 203, FRAME0_NS + SPAN_NS + 63'd1, 1'b0, 1'b0);
		send_point(60000, 1, 2, 14, 204, FRAME0_NS - SPAN_NS - 63'd1, 1'b0, 1'b0);
		send_point(60000, 1, 2, 15, 205, FRAME0_NS - SPAN_NS - 63'd2, 1'b0, 1'b0);
		send_point(60000, 1, 2, 16, 206, 63'd0, 1'b0, 1'b0);
		send_point(70000, -3, 4, 17, 207, 63'd0, 1'b0, 1'b1);
		send_point(-262144, -262144, -262144, 0, 0, 63'd10, 1'b0, 1'b0);
		send_point(262143, 262143, 262143, 255, 255, TS_MAX, 1'b0, 1'b0);
		// Self-body zones, each with a near miss where one helps.
		send_point(0, 0, 0, 30, 200, 63'd20, 1'b0, 1'b0);
		send_point(-600, 300, 0, 31, 200, 63'd21, 1'b0, 1'b0);
		send_point(-300, 1700, 0, 32, 5, 63'd22, 1'b0, 1'b0);
		send_point(-300, -1700, 0, 33, 8, 63'd23, 1'b0, 1'b0);
		send_point(-50, 450, -1000, 34, 10, 63'd24, 1'b0, 1'b0);
		send_point(800, 0, 0, 35, 9, 63'd25, 1'b0, 1'b0);
		send_point(-3000, 500, 0, 36, 3, 63'd26, 1'b0, 1'b0);
		send_point(-3000, -500, 0, 37, 6, 63'd27, 1'b0, 1'b0);
		send_point(100, 550, 0, 38, 14, 63'd28, 1'b0, 1'b0);
		send_point(-1400, 100, 0, 39, 12, 63'd29, 1'b0, 1'b0);
		send_point(1000, 1000, 1000, 40, 40, 63'd30, 1'b1, 1'b0);
		wait_for_drain();

		write_mode(MODE_NO_TIME);
		send_random_points(300);
		wait_for_drain();
		write_mode(MODE_NO_RING);
		send_random_points(300);
		wait_for_drain();
		write_mode(MODE_FULL);
		send_random_points(450);
		wait_for_drain();
		send_random_points(450);
		wait_for_drain();
		write_mode(MODE_NO_RING_ALT);
		send_random_points(200);
		wait_for_drain();
		write_mode(MODE_FULL);
		send_random_points(200);
		wait_for_drain();

		if (mismatch_count == 0 && pending_points == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
